// File: rtl/core/integer_literal_parser_core_assert.svh
// Assertion macros for the integer literal parser core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef INTEGER_LITERAL_PARSER_CORE_ASSERT_SVH
`define INTEGER_LITERAL_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define ILP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define ILP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ilp_pkg.sv
// Shared types and constants for the integer literal parser core.
// No dependencies; imported by the core, ilp_step and ilp_final.
package ilp_pkg;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_BODY   = 5'b00010,
    PH_ZERO   = 5'b00100,
    PH_DIGITS = 5'b01000,
    PH_SUFFIX = 5'b10000
  } ilp_phase_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_BIN = 2'd2
  } ilp_radix_t;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_I32   = 3'd1,
    KIND_U32   = 3'd2,
    KIND_ISIZE = 3'd3,
    KIND_USIZE = 3'd4
  } ilp_kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_NUMBER = 2'd1,
    ST_BAD_SUFFIX = 2'd2,
    ST_RANGE      = 2'd3
  } ilp_status_t;

  localparam int unsigned SUF_DEPTH = 5;
  localparam logic [2:0] SUF_TOO_LONG = 3'(SUF_DEPTH + 1);

  // Characters of interest
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_UNDER = "_";
  localparam logic [7:0] CH_LX    = "x";
  localparam logic [7:0] CH_LB    = "b";
  localparam logic [7:0] CH_LA    = "a";
  localparam logic [7:0] CH_LF    = "f";
  localparam logic [7:0] CH_UA    = "A";
  localparam logic [7:0] CH_UZ    = "Z";

  // Accepted suffixes, first character in the top byte
  localparam logic [23:0] SFX_I32   = "i32";
  localparam logic [23:0] SFX_U32   = "u32";
  localparam logic [39:0] SFX_ISIZE = "isize";
  localparam logic [39:0] SFX_USIZE = "usize";

  // Parser state captured when the last beat of a literal is processed
  typedef struct packed {
    logic                           is_negative;
    logic [63:0]                    magnitude;
    logic                           too_large;
    logic                           digit_seen;
    logic [SUF_DEPTH-1:0][7:0]      suffix_chars;
    logic [2:0]                     suffix_length;
  } ilp_snap_t;

  // One result beat
  typedef struct packed {
    logic signed [63:0] value;
    logic               suffix_present;
    ilp_kind_t          suffix_kind;
    ilp_status_t        status;
  } ilp_res_t;

endpackage

// File: rtl/core/ilp_in_if.sv
// Character channel of the integer literal parser core.
// Depends on nothing; valid/ready handshake with ch and last payload.
interface ilp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

// File: rtl/core/ilp_out_if.sv
// Result channel of the integer literal parser core.
// Depends on nothing; valid/ready handshake with the parsed result payload.
interface ilp_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic               suffix_present;
  logic [2:0]         suffix_kind;
  logic [1:0]         status;

  modport source (output valid, output value, output suffix_present, output suffix_kind,
                  output status, input ready);
  modport sink   (input valid, input value, input suffix_present, input suffix_kind,
                  input status, output ready);
endinterface

// File: rtl/core/integer_literal_parser_core.sv
// Integer literal parser core.
// One ASCII character per beat arrives on in_bus (ch, last). The literal is an
// optional sign, an optional 0x/0b prefix, digits and underscores, and an
// optional suffix i32, u32, isize or usize. On the beat marked last, one
// result beat leaves on out_bus: signed 64-bit value, suffix_present,
// suffix_kind and status; beats without last produce nothing.
// Throughput: one character per cycle, back to back across literals, as long
// as a last character finds room in the snapshot register. The last
// character passes through the input register, then the snapshot register,
// then the output register, which drives out_bus.
// Reset (rst_n low, synchronous) empties all stages and puts the parser at the
// start of a literal. When out_bus.ready is low, the output register holds its
// beat; characters that are not last keep flowing, and a last character waits
// in the input register only once the snapshot and output registers are full,
// after which in_bus.ready drops.
// PTR_BITS (32 to 64) sets the range of the isize and usize suffixes.
module integer_literal_parser_core import ilp_pkg::*; #(
  parameter int PTR_BITS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  ilp_in_if.sink    in_bus,
  ilp_out_if.source out_bus
);

  `include "integer_literal_parser_core_assert.svh"

  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_last_r;
  logic       s1_adv;
  logic       snap_valid;
  logic       snap_take;
  logic       snap_free;
  ilp_snap_t  snap;
  logic       out_valid_r;
  ilp_res_t   res_r;

  // Stage advance: only a last beat needs room downstream
  assign snap_free    = !snap_valid || snap_take;
  assign s1_adv       = s1_valid_r && (!s1_last_r || snap_free);
  assign in_bus.ready = !s1_valid_r || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_ch_r   <= in_bus.ch;
      s1_last_r <= in_bus.last;
    end
  end

  ilp_step u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (s1_adv),
    .ch           (s1_ch_r),
    .last         (s1_last_r),
    .snap_take    (snap_take),
    .snap_valid_r (snap_valid),
    .snap_r       (snap)
  );

  ilp_final #(
    .PTR_BITS (PTR_BITS)
  ) u_final (
    .clk         (clk),
    .rst_n       (rst_n),
    .snap_valid  (snap_valid),
    .snap        (snap),
    .out_ready   (out_bus.ready),
    .snap_take   (snap_take),
    .out_valid_r (out_valid_r),
    .res_r       (res_r)
  );

  // Result channel
  assign out_bus.valid          = out_valid_r;
  assign out_bus.value          = res_r.value;
  assign out_bus.suffix_present = res_r.suffix_present;
  assign out_bus.suffix_kind    = res_r.suffix_kind;
  assign out_bus.status         = res_r.status;

  // Checks
  `ILP_ASSERT_NEXT(a_last_to_snap, s1_adv && s1_last_r, snap_valid,
                   "last beat did not reach the snapshot register")
  `ILP_ASSERT_NEXT(a_snap_to_out, snap_take, out_valid_r,
                   "snapshot taken but no result beat followed")
  `ILP_ASSERT_NOW(a_err_zero, out_valid_r && res_r.status != ST_OK, res_r.value == 64'sd0,
                  "nonzero value on an error result")
  `ILP_ASSERT_NOW(a_kind_needs_suffix, out_valid_r && !res_r.suffix_present,
                  res_r.suffix_kind == KIND_NONE, "suffix kind without a suffix")

endmodule

// File: rtl/core/ilp_step.sv
// Per-character state update of the integer literal parser.
// Holds the parser state and the end-of-literal snapshot; uses ilp_pkg.
module ilp_step import ilp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  logic [7:0] ch,
  input  logic      last,
  input  logic      snap_take,
  output logic      snap_valid_r,
  output ilp_snap_t snap_r
);

  ilp_phase_t                phase_r, phase_nxt;
  logic                      neg_r, neg_nxt;
  ilp_radix_t                radix_r, radix_nxt;
  logic [63:0]               mag_r, mag_nxt;
  logic                      big_r, big_nxt;
  logic                      seen_r, seen_nxt;
  logic [SUF_DEPTH-1:0][7:0] suf_r, suf_nxt;
  logic [2:0]                len_r, len_nxt;
  logic                      snap_valid_nxt;

  logic       run_digit;
  logic       push;
  logic [7:0] low_ch;
  logic [4:0] dval;
  logic [67:0] prod;
  logic       ovf;

  // Digit value of c in radix rx, 16 when not a digit
  function automatic logic [4:0] digit_of(input logic [7:0] c, input ilp_radix_t rx);
    logic [4:0] d;
    d = 5'd16;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 5'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = 5'(c - CH_LA) + 5'd10;
    end
    case (rx)
      RX_HEX:  digit_of = d;
      RX_BIN:  digit_of = (d < 5'd2) ? d : 5'd16;
      default: digit_of = (d < 5'd10) ? d : 5'd16;
    endcase
  endfunction

  assign low_ch = (ch >= CH_UA && ch <= CH_UZ) ? ch + 8'd32 : ch;
  assign dval   = digit_of(low_ch, radix_r);

  // Shift-and-add accumulate; anything above bit 63 is an overflow
  always_comb begin
    case (radix_r)
      RX_HEX:  prod = {mag_r, 4'd0} + 68'(dval[3:0]);
      RX_BIN:  prod = {3'd0, mag_r, 1'b0} + 68'(dval[3:0]);
      default: prod = {1'b0, mag_r, 3'd0} + {3'd0, mag_r, 1'b0} + 68'(dval[3:0]);
    endcase
  end
  assign ovf = |prod[67:64];

  // Next state for one character
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    radix_nxt = radix_r;
    mag_nxt   = mag_r;
    big_nxt   = big_r;
    seen_nxt  = seen_r;
    suf_nxt   = suf_r;
    len_nxt   = len_r;
    run_digit = 1'b0;
    push      = 1'b0;

    unique case (phase_r)
      PH_START, PH_BODY: begin
        if (phase_r == PH_START && (ch == CH_MINUS || ch == CH_PLUS)) begin
          neg_nxt   = (ch == CH_MINUS);
          phase_nxt = PH_BODY;
        end else if (ch == CH_ZERO) begin
          seen_nxt  = 1'b1;
          phase_nxt = PH_ZERO;
        end else begin
          phase_nxt = PH_DIGITS;
          run_digit = 1'b1;
        end
      end
      PH_ZERO: begin
        phase_nxt = PH_DIGITS;
        if (low_ch == CH_LX) begin
          radix_nxt = RX_HEX;
        end else if (low_ch == CH_LB) begin
          radix_nxt = RX_BIN;
        end else begin
          run_digit = 1'b1;
        end
      end
      PH_DIGITS: run_digit = 1'b1;
      PH_SUFFIX: push = 1'b1;
      default:   phase_nxt = PH_START;
    endcase

    // Digit, separator, or first suffix character
    if (run_digit && ch != CH_UNDER) begin
      if (dval[4]) begin
        phase_nxt = PH_SUFFIX;
        push      = 1'b1;
      end else begin
        seen_nxt = 1'b1;
        if (!big_r) begin
          if (ovf) begin
            big_nxt = 1'b1;
          end else begin
            mag_nxt = prod[63:0];
          end
        end
      end
    end

    // Suffix store, length saturates as too long
    if (push) begin
      if (len_r < 3'(SUF_DEPTH)) begin
        for (int i = 0; i < SUF_DEPTH; i++) begin
          if (len_r == 3'(i)) begin
            suf_nxt[i] = ch;
          end
        end
        len_nxt = len_r + 3'd1;
      end else begin
        len_nxt = SUF_TOO_LONG;
      end
    end
  end

  assign snap_valid_nxt = (step_en && last) ? 1'b1 : (snap_take ? 1'b0 : snap_valid_r);

  // Control state; back to start after the last beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      neg_r        <= 1'b0;
      radix_r      <= RX_DEC;
      mag_r        <= '0;
      big_r        <= 1'b0;
      seen_r       <= 1'b0;
      len_r        <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      snap_valid_r <= snap_valid_nxt;
      if (step_en) begin
        if (last) begin
          phase_r <= PH_START;
          neg_r   <= 1'b0;
          radix_r <= RX_DEC;
          mag_r   <= '0;
          big_r   <= 1'b0;
          seen_r  <= 1'b0;
          len_r   <= '0;
        end else begin
          phase_r <= phase_nxt;
          neg_r   <= neg_nxt;
          radix_r <= radix_nxt;
          mag_r   <= mag_nxt;
          big_r   <= big_nxt;
          seen_r  <= seen_nxt;
          len_r   <= len_nxt;
        end
      end
    end
  end

  // Suffix characters and snapshot payload
  always_ff @(posedge clk) begin
    if (step_en) begin
      suf_r <= suf_nxt;
    end
    if (step_en && last) begin
      snap_r.is_negative   <= neg_nxt;
      snap_r.magnitude     <= mag_nxt;
      snap_r.too_large     <= big_nxt;
      snap_r.digit_seen    <= seen_nxt;
      snap_r.suffix_chars  <= suf_nxt;
      snap_r.suffix_length <= len_nxt;
    end
  end

endmodule

// File: rtl/core/ilp_final.sv
// Result classification of the integer literal parser: suffix match,
// range checks, sign, and the output register. Uses ilp_pkg.
module ilp_final import ilp_pkg::*; #(
  parameter int PTR_BITS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      snap_valid,
  input  ilp_snap_t snap,
  input  logic      out_ready,
  output logic      snap_take,
  output logic      out_valid_r,
  output ilp_res_t  res_r
);

  localparam logic [63:0] SMAX = (64'd1 << (PTR_BITS - 1)) - 64'd1;
  localparam logic [63:0] UMAX = (PTR_BITS >= 64) ? {64{1'b1}}
                                                  : ((64'd1 << PTR_BITS) - 64'd1);

  logic        out_free;
  ilp_kind_t   kind;
  logic        neg;
  logic [63:0] mag;
  logic        bad_num;
  logic        in_range;
  ilp_res_t    res_nxt;

  assign neg = snap.is_negative;
  assign mag = snap.magnitude;

  // Suffix lookup, exact length and case
  always_comb begin
    kind = KIND_NONE;
    if (snap.suffix_length == 3'd3) begin
      if ({snap.suffix_chars[0], snap.suffix_chars[1], snap.suffix_chars[2]} == SFX_I32) begin
        kind = KIND_I32;
      end else if ({snap.suffix_chars[0], snap.suffix_chars[1],
                    snap.suffix_chars[2]} == SFX_U32) begin
        kind = KIND_U32;
      end
    end else if (snap.suffix_length == 3'd5) begin
      if ({snap.suffix_chars[0], snap.suffix_chars[1], snap.suffix_chars[2],
           snap.suffix_chars[3], snap.suffix_chars[4]} == SFX_ISIZE) begin
        kind = KIND_ISIZE;
      end else if ({snap.suffix_chars[0], snap.suffix_chars[1], snap.suffix_chars[2],
                    snap.suffix_chars[3], snap.suffix_chars[4]} == SFX_USIZE) begin
        kind = KIND_USIZE;
      end
    end
  end

  // No digit, accumulate overflow, or beyond signed 64-bit
  assign bad_num = !snap.digit_seen || snap.too_large ||
                   (mag[63] && (!neg || (|mag[62:0])));

  always_comb begin
    case (kind)
      KIND_I32:   in_range = neg ? (mag <= 64'h8000_0000) : (mag <= 64'h7FFF_FFFF);
      KIND_U32:   in_range = neg ? (mag == 64'd0) : (mag[63:32] == 32'd0);
      KIND_ISIZE: in_range = neg ? (mag <= SMAX + 64'd1) : (mag <= SMAX);
      KIND_USIZE: in_range = neg ? (mag == 64'd0) : (mag <= UMAX);
      default:    in_range = 1'b1;
    endcase
  end

  always_comb begin
    res_nxt.suffix_present = (snap.suffix_length != 3'd0);
    res_nxt.suffix_kind    = kind;
    res_nxt.value          = '0;
    if (bad_num) begin
      res_nxt.status = ST_BAD_NUMBER;
    end else if (snap.suffix_length != 3'd0 && kind == KIND_NONE) begin
      res_nxt.status = ST_BAD_SUFFIX;
    end else if (!in_range) begin
      res_nxt.status = ST_RANGE;
    end else begin
      res_nxt.status = ST_OK;
      res_nxt.value  = neg ? $signed(64'd0 - mag) : $signed(mag);
    end
  end

  // Output register
  assign out_free  = !out_valid_r || out_ready;
  assign snap_take = snap_valid && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      res_r <= res_nxt;
    end
  end

endmodule
